// ===== rtl/core/assert_macros.svh =====
// shared assertion macros for the lexer checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is low
`define KL_ASSERT_CLK(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// property checked only while reset is held low
`define KL_ASSERT_RST(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) !rst_n |-> prop) else $error(msg);

`endif

// ===== rtl/core/kl_pkg.sv =====
package kl_pkg;

	localparam int MAX_TOKEN_CHARS = 8;
	localparam int KEYWORD_COUNT   = 6;
	localparam int KW_SLOTS        = 6;
	localparam int QUEUE_DEPTH     = 4;

	localparam int KIND_W = 5;
	localparam int TEXT_W = 64;
	localparam int LEN_W  = 4;
	localparam int NUM_W  = 15;
	localparam int ROW_W  = 16;
	localparam int ACC_W  = 16;

	localparam int OUT_DATA_W = 104;
	localparam int OUT_USER_W = 6;

	localparam int NUM_LIMIT = 32767;

	typedef logic [KIND_W-1:0] kind_t;

	// token codes
	localparam kind_t TK_END    = 5'd0;
	localparam kind_t TK_IDENT  = 5'd10;
	localparam kind_t TK_NUMBER = 5'd11;
	localparam kind_t TK_MUL    = 5'd13;
	localparam kind_t TK_DIV    = 5'd14;
	localparam kind_t TK_ADD    = 5'd15;
	localparam kind_t TK_SUB    = 5'd16;
	localparam kind_t TK_COLON  = 5'd17;
	localparam kind_t TK_ASSIGN = 5'd18;
	localparam kind_t TK_GT     = 5'd20;
	localparam kind_t TK_NE     = 5'd21;
	localparam kind_t TK_LE     = 5'd22;
	localparam kind_t TK_LT     = 5'd23;
	localparam kind_t TK_GE     = 5'd24;
	localparam kind_t TK_EQ     = 5'd25;
	localparam kind_t TK_SEMI   = 5'd26;
	localparam kind_t TK_LPAREN = 5'd27;
	localparam kind_t TK_RPAREN = 5'd28;

	// characters with a meaning of their own
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;

	// keyword spellings, first character in the low byte, zero padded
	localparam logic [TEXT_W-1:0] KW_TEXT [0:KW_SLOTS-1] = '{
		64'h0000_7463_656C_6573, // select
		64'h0000_0000_6D6F_7266, // from
		64'h0000_0065_7265_6877, // where
		64'h0000_7472_6573_6E69, // insert
		64'h0000_6574_6165_7263, // create
		64'h0000_0000_0064_6E61  // and
	};
	localparam logic [LEN_W-1:0] KW_LEN [0:KW_SLOTS-1] = '{
		4'd6, 4'd4, 4'd5, 4'd6, 4'd6, 4'd3
	};

	typedef struct packed {
		kind_t              kind;
		logic               is_error;
		logic [TEXT_W-1:0]  text;
		logic [LEN_W-1:0]   len;
		logic [NUM_W-1:0]   num;
		logic [ROW_W-1:0]   row;
		logic               last;
	} token_t;

	// up to two tokens written into the queue in one cycle
	typedef struct packed {
		logic [1:0] count;
		token_t     first;
		token_t     second;
	} push_t;

endpackage

// ===== rtl/core/kl_front.sv =====
module kl_front #(
	parameter int MAX_TOKEN_CHARS = kl_pkg::MAX_TOKEN_CHARS,
	parameter int KEYWORD_COUNT   = kl_pkg::KEYWORD_COUNT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [7:0]      in_byte,
	input  logic            room,
	output logic            in_ready,
	output kl_pkg::push_t   push
);

	localparam int BUF_W  = 8 * MAX_TOKEN_CHARS;
	localparam int CNT_W  = $clog2(MAX_TOKEN_CHARS + 2);
	localparam int LEN_W  = kl_pkg::LEN_W;
	localparam int ACC_W  = kl_pkg::ACC_W;
	localparam int ROW_W  = kl_pkg::ROW_W;
	localparam int NUM_W  = kl_pkg::NUM_W;
	localparam int TEXT_W = kl_pkg::TEXT_W;
	localparam int MUL_W  = ACC_W + 4;

	typedef enum logic [5:0] {
		MODE_IDLE   = 6'b000001,
		MODE_IDENT  = 6'b000010,
		MODE_NUMBER = 6'b000100,
		MODE_LT     = 6'b001000,
		MODE_GT     = 6'b010000,
		MODE_COLON  = 6'b100000
	} mode_t;

	mode_t              mode_q, mode_d, idle_mode;
	logic [BUF_W-1:0]   text_q, text_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [ACC_W-1:0]   acc_q, acc_d, acc_sat;
	logic [ROW_W-1:0]   row_q, row_d;
	logic [MUL_W-1:0]   acc_x10;
	logic [LEN_W-1:0]   id_len;
	kl_pkg::kind_t      kw_kind;
	kl_pkg::token_t     pend_tok, idle_tok;
	logic               accept, letter, digit, alnum;
	logic               ident_cont, number_cont;
	logic               pend_hit, pend_done, absorbed, idle_hit, idle_emit;

	assign in_ready = room;
	assign accept   = in_valid & room;

	assign letter = ((in_byte >= 8'h61) && (in_byte <= 8'h7A)) ||
	                ((in_byte >= 8'h41) && (in_byte <= 8'h5A));
	assign digit  = (in_byte >= 8'h30) && (in_byte <= 8'h39);
	assign alnum  = letter | digit;

	assign ident_cont  = (mode_q == MODE_IDENT) && alnum;
	assign number_cont = (mode_q == MODE_NUMBER) && digit;
	assign absorbed    = ident_cont | number_cont | pend_done;
	assign idle_emit   = idle_hit & ~absorbed;

	// acc * 10 + digit, saturating one above the limit
	assign acc_x10 = (MUL_W'(acc_q) << 3) + (MUL_W'(acc_q) << 1) + MUL_W'(in_byte[3:0]);
	assign acc_sat = (acc_x10 > MUL_W'(kl_pkg::NUM_LIMIT)) ?
	                 ACC_W'(kl_pkg::NUM_LIMIT + 1) : acc_x10[ACC_W-1:0];

	assign id_len = (cnt_q > CNT_W'(MAX_TOKEN_CHARS)) ?
	                LEN_W'(MAX_TOKEN_CHARS) : LEN_W'(cnt_q);

	// keyword match, unused bytes of the buffer are always zero
	always_comb begin
		kw_kind = kl_pkg::TK_IDENT;
		for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
			if ((cnt_q == CNT_W'(kl_pkg::KW_LEN[k])) &&
			    (TEXT_W'(text_q) == kl_pkg::KW_TEXT[k]))
				kw_kind = kl_pkg::kind_t'(k + 1);
		end
	end

	// token finished by this byte
	always_comb begin
		pend_hit  = 1'b0;
		pend_done = 1'b0;
		pend_tok  = '0;
		pend_tok.row = row_q;
		case (mode_q)
			MODE_IDENT: begin
				if (!alnum) begin
					pend_hit      = 1'b1;
					pend_tok.kind = kw_kind;
					pend_tok.text = TEXT_W'(text_q);
					pend_tok.len  = id_len;
				end
			end
			MODE_NUMBER: begin
				if (!digit) begin
					pend_hit      = 1'b1;
					pend_tok.kind = kl_pkg::TK_NUMBER;
					if (acc_q > ACC_W'(kl_pkg::NUM_LIMIT))
						pend_tok.is_error = 1'b1;
					else
						pend_tok.num = acc_q[NUM_W-1:0];
				end
			end
			MODE_LT: begin
				pend_hit = 1'b1;
				if (in_byte == kl_pkg::CH_GT) begin
					pend_done     = 1'b1;
					pend_tok.kind = kl_pkg::TK_NE;
					pend_tok.text = TEXT_W'({kl_pkg::CH_GT, kl_pkg::CH_LT});
					pend_tok.len  = LEN_W'(2);
				end else if (in_byte == kl_pkg::CH_EQ) begin
					pend_done     = 1'b1;
					pend_tok.kind = kl_pkg::TK_LE;
					pend_tok.text = TEXT_W'({kl_pkg::CH_EQ, kl_pkg::CH_LT});
					pend_tok.len  = LEN_W'(2);
				end else begin
					pend_tok.kind = kl_pkg::TK_LT;
					pend_tok.text = TEXT_W'(kl_pkg::CH_LT);
					pend_tok.len  = LEN_W'(1);
				end
			end
			MODE_GT: begin
				pend_hit = 1'b1;
				if (in_byte == kl_pkg::CH_EQ) begin
					pend_done     = 1'b1;
					pend_tok.kind = kl_pkg::TK_GE;
					pend_tok.text = TEXT_W'({kl_pkg::CH_EQ, kl_pkg::CH_GT});
					pend_tok.len  = LEN_W'(2);
				end else begin
					pend_tok.kind = kl_pkg::TK_GT;
					pend_tok.text = TEXT_W'(kl_pkg::CH_GT);
					pend_tok.len  = LEN_W'(1);
				end
			end
			MODE_COLON: begin
				pend_hit = 1'b1;
				if (in_byte == kl_pkg::CH_EQ) begin
					pend_done     = 1'b1;
					pend_tok.kind = kl_pkg::TK_ASSIGN;
					pend_tok.text = TEXT_W'({kl_pkg::CH_EQ, kl_pkg::CH_COLON});
					pend_tok.len  = LEN_W'(2);
				end else begin
					pend_tok.kind = kl_pkg::TK_COLON;
					pend_tok.text = TEXT_W'(kl_pkg::CH_COLON);
					pend_tok.len  = LEN_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// byte seen with nothing pending
	always_comb begin
		idle_hit  = 1'b0;
		idle_mode = MODE_IDLE;
		idle_tok  = '0;
		idle_tok.row  = row_q;
		idle_tok.text = TEXT_W'(in_byte);
		idle_tok.len  = LEN_W'(1);
		if (letter) begin
			idle_mode = MODE_IDENT;
		end else if (digit) begin
			idle_mode = MODE_NUMBER;
		end else begin
			case (in_byte)
				kl_pkg::CH_SP, kl_pkg::CH_CR, kl_pkg::CH_LF: begin
				end
				kl_pkg::CH_LT:    idle_mode = MODE_LT;
				kl_pkg::CH_GT:    idle_mode = MODE_GT;
				kl_pkg::CH_COLON: idle_mode = MODE_COLON;
				kl_pkg::CH_STAR: begin
					idle_hit      = 1'b1;
					idle_tok.kind = kl_pkg::TK_MUL;
				end
				kl_pkg::CH_SLASH: begin
					idle_hit      = 1'b1;
					idle_tok.kind = kl_pkg::TK_DIV;
				end
				kl_pkg::CH_PLUS: begin
					idle_hit      = 1'b1;
					idle_tok.kind = kl_pkg::TK_ADD;
				end
				kl_pkg::CH_MINUS: begin
					idle_hit      = 1'b1;
					idle_tok.kind = kl_pkg::TK_SUB;
				end
				kl_pkg::CH_EQ: begin
					idle_hit      = 1'b1;
					idle_tok.kind = kl_pkg::TK_EQ;
				end
				kl_pkg::CH_SEMI: begin
					idle_hit      = 1'b1;
					idle_tok.kind = kl_pkg::TK_SEMI;
				end
				kl_pkg::CH_LPAR: begin
					idle_hit      = 1'b1;
					idle_tok.kind = kl_pkg::TK_LPAREN;
				end
				kl_pkg::CH_RPAR: begin
					idle_hit      = 1'b1;
					idle_tok.kind = kl_pkg::TK_RPAREN;
				end
				kl_pkg::CH_HASH: begin
					idle_hit      = 1'b1;
					idle_tok.kind = kl_pkg::TK_END;
				end
				default: begin
					// illegal character
					idle_hit          = 1'b1;
					idle_tok.kind     = kl_pkg::TK_END;
					idle_tok.is_error = 1'b1;
					idle_tok.text     = '0;
					idle_tok.len      = '0;
				end
			endcase
		end
	end

	always_comb begin
		mode_d = mode_q;
		text_d = text_q;
		cnt_d  = cnt_q;
		acc_d  = acc_q;
		row_d  = row_q;
		if (ident_cont) begin
			if (cnt_q < CNT_W'(MAX_TOKEN_CHARS)) begin
				for (int i = 0; i < MAX_TOKEN_CHARS; i++) begin
					if (cnt_q == CNT_W'(i))
						text_d[8*i +: 8] = in_byte;
				end
				cnt_d = cnt_q + CNT_W'(1);
			end else begin
				cnt_d = CNT_W'(MAX_TOKEN_CHARS + 1);
			end
		end else if (number_cont) begin
			acc_d = acc_sat;
		end else if (pend_done) begin
			mode_d = MODE_IDLE;
		end else begin
			mode_d = idle_mode;
			if (letter) begin
				text_d = BUF_W'(in_byte);
				cnt_d  = CNT_W'(1);
			end
			if (digit)
				acc_d = ACC_W'(in_byte[3:0]);
			if ((in_byte == kl_pkg::CH_LF) && (row_q != '1))
				row_d = row_q + ROW_W'(1);
			if (in_byte == kl_pkg::CH_HASH)
				row_d = ROW_W'(1);
		end
	end

	always_comb begin
		push.count = accept ? (2'(pend_hit) + 2'(idle_emit)) : 2'd0;
		push.first = pend_hit ? pend_tok : idle_tok;
		push.first.last = ~(pend_hit & idle_emit);
		push.second = idle_tok;
		push.second.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			text_q <= '0;
			cnt_q  <= '0;
			acc_q  <= '0;
			row_q  <= ROW_W'(1);
		end else if (accept) begin
			mode_q <= mode_d;
			text_q <= text_d;
			cnt_q  <= cnt_d;
			acc_q  <= acc_d;
			row_q  <= row_d;
		end
	end

endmodule

// ===== rtl/core/kl_queue.sv =====
module kl_queue #(
	parameter int QUEUE_DEPTH = kl_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  kl_pkg::push_t   push,
	input  logic            pop,
	output logic            room,
	output logic            not_empty,
	output kl_pkg::token_t  head
);

	// depth is a power of two, at least two
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	kl_pkg::token_t     mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   count_q;
	logic [PTR_W-1:0]   wr_next;

	assign wr_next   = wr_q + PTR_W'(1);
	assign room      = count_q <= CNT_W'(QUEUE_DEPTH - 2);
	assign not_empty = count_q != '0;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem_q[wr_q] <= push.first;
		if (push.count == 2'd2)
			mem_q[wr_next] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(push.count);
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

endmodule

// ===== rtl/core/kl_back.sv =====
module kl_back (
	input  logic            clk,
	input  logic            arst_n,
	input  kl_pkg::token_t  head,
	input  logic            not_empty,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output kl_pkg::token_t  out_tok
);

	logic           valid_q;
	kl_pkg::token_t tok_q;

	// refill whenever the register is empty or being drained
	assign pop       = not_empty & (~valid_q | out_ready);
	assign out_valid = valid_q;
	assign out_tok   = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			tok_q <= head;
	end

endmodule

// ===== rtl/core/keyword_lexer.sv =====
// channel  dir  handshake                      payload
// s_axis   in   s_axis_tvalid / s_axis_tready  tdata: in_byte
// m_axis   out  m_axis_tvalid / m_axis_tready  tdata: text, length, value, row
//                                              tuser: kind, error; tlast: last of run
//
// one byte accepted per cycle while s_axis_tready is high; a result passes the queue
// and output register. A byte that closes a pending token and makes its own gives two
// items; output register drains one per cycle, so a burst can hold s_axis_tready low
// s_axis_tready is high while the token queue has two free slots
// arst_n clears the scan state, sets the row to one and empties queue and output
module keyword_lexer #(
	parameter int MAX_TOKEN_CHARS = kl_pkg::MAX_TOKEN_CHARS,
	parameter int KEYWORD_COUNT   = kl_pkg::KEYWORD_COUNT,
	parameter int QUEUE_DEPTH     = kl_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // in_byte
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// token_text, text_length, number_value, row_number, zero pad
	output logic [kl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// token_kind, is_error
	output logic [kl_pkg::OUT_USER_W-1:0] m_axis_tuser,
	output logic                          m_axis_tlast   // last_of_run
);

	kl_pkg::push_t  push;
	kl_pkg::token_t head, out_tok;
	logic           room, not_empty, pop;

	// front: classify each byte, update scan state, emit up to two tokens
	kl_front #(
		.MAX_TOKEN_CHARS (MAX_TOKEN_CHARS),
		.KEYWORD_COUNT   (KEYWORD_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_byte  (s_axis_tdata),
		.room     (room),
		.in_ready (s_axis_tready),
		.push     (push)
	);

	// short token queue between front and back
	kl_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.room      (room),
		.not_empty (not_empty),
		.head      (head)
	);

	// back: output register toward the sink
	kl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.not_empty (not_empty),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_tok   (out_tok)
	);

	// pack the token onto the bus fields
	assign m_axis_tdata = kl_pkg::OUT_DATA_W'({out_tok.row, out_tok.num,
	                                           out_tok.len, out_tok.text});
	assign m_axis_tuser = {out_tok.is_error, out_tok.kind};
	assign m_axis_tlast = out_tok.last;

endmodule

// ===== rtl/core/kl_checker.sv =====
`include "assert_macros.svh"

module kl_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [103:0] m_axis_tdata,
	input logic [5:0]   m_axis_tuser
);

	// a stalled item holds still
	`KL_ASSERT_CLK(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled item changed")

	// error items carry no text
	`KL_ASSERT_CLK(a_err_empty, clk, arst_n, m_axis_tvalid && m_axis_tuser[5] |-> m_axis_tdata[67:0] == 68'd0, "error item with text")

	// only number items carry a value
	`KL_ASSERT_CLK(a_num_kind, clk, arst_n, m_axis_tvalid && m_axis_tuser[4:0] != kl_pkg::TK_NUMBER |-> m_axis_tdata[82:68] == 15'd0, "value on non-number item")

	// row count starts at one and never wraps to zero; length is at most 8
	`KL_ASSERT_CLK(a_row_nonzero, clk, arst_n, m_axis_tvalid |-> m_axis_tdata[98:83] != 16'd0 && m_axis_tdata[67:64] <= 4'd8, "bad row or length")

	`KL_ASSERT_RST(a_rst_quiet, clk, arst_n, !m_axis_tvalid, "output valid in reset")

endmodule

bind keyword_lexer kl_checker u_kl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ===== bench/keyword_lexer_tb.sv =====
`timescale 1ns / 100ps

module keyword_lexer_tb;

	localparam int TEXT_W = kl_pkg::TEXT_W;
	localparam int LEN_W  = kl_pkg::LEN_W;
	localparam int NUM_W  = kl_pkg::NUM_W;
	localparam int ROW_W  = kl_pkg::ROW_W;

	// what the scanner is in the middle of between two bytes
	typedef enum logic [5:0] {
		SCAN_IDLE    = 6'b000001,
		SCAN_WORD    = 6'b000010,
		SCAN_DIGITS  = 6'b000100,
		SCAN_LESS    = 6'b001000,
		SCAN_GREATER = 6'b010000,
		SCAN_COLON   = 6'b100000
	} scan_mode_t;

	// token model and the queue of tokens still owed by the lexer
	class token_scoreboard_t;
		kl_pkg::token_t    token_q[$];
		int unsigned       errors;
		scan_mode_t        mode;
		logic [TEXT_W-1:0] word;
		int unsigned       n_chars;
		int unsigned       acc;
		logic [ROW_W-1:0]  row_cnt;

		function new();
			errors  = 0;
			mode    = SCAN_IDLE;
			word    = '0;
			n_chars = 0;
			acc     = 0;
			row_cnt = ROW_W'(1);
		endfunction

		function bit is_alpha(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		endfunction

		function bit is_digit(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function void push(kl_pkg::kind_t k, logic e, logic [TEXT_W-1:0] t,
				logic [LEN_W-1:0] n, logic [NUM_W-1:0] v);
			kl_pkg::token_t tok;
			tok.kind     = k;
			tok.is_error = e;
			tok.text     = t;
			tok.len      = n;
			tok.num      = v;
			tok.row      = row_cnt;
			tok.last     = 1'b0;
			token_q.push_back(tok);
		endfunction

		// one accepted byte: close the pending token, then handle the byte itself
		function void note_byte(logic [7:0] c);
			int unsigned   size_at_entry;
			int unsigned   v;
			bit            done;
			bit            has_op;
			kl_pkg::kind_t op;
			size_at_entry = token_q.size();
			done   = 1'b0;
			has_op = 1'b1;
			op     = kl_pkg::TK_END;
			case (mode)
				SCAN_WORD: begin
					if (is_alpha(c) || is_digit(c)) begin
						// keep the first characters, then mark the word as too long
						if (n_chars < kl_pkg::MAX_TOKEN_CHARS) begin
							word[8*n_chars +: 8] = c;
							n_chars++;
						end else begin
							n_chars = kl_pkg::MAX_TOKEN_CHARS + 1;
						end
						done = 1'b1;
					end else begin
						op = kl_pkg::TK_IDENT;
						for (int i = kl_pkg::KEYWORD_COUNT - 1; i >= 0; i--)
							if (n_chars == 32'(kl_pkg::KW_LEN[i]) &&
									word == kl_pkg::KW_TEXT[i])
								op = kl_pkg::kind_t'(i + 1);
						push(op, 1'b0, word, LEN_W'((n_chars > kl_pkg::MAX_TOKEN_CHARS) ?
							kl_pkg::MAX_TOKEN_CHARS : n_chars), '0);
					end
				end
				SCAN_DIGITS: begin
					if (is_digit(c)) begin
						v    = acc * 10 + 32'(c - "0");
						acc  = (v > kl_pkg::NUM_LIMIT) ? kl_pkg::NUM_LIMIT + 1 : v;
						done = 1'b1;
					end else if (acc > kl_pkg::NUM_LIMIT) begin
						push(kl_pkg::TK_NUMBER, 1'b1, '0, '0, '0);
					end else begin
						push(kl_pkg::TK_NUMBER, 1'b0, '0, '0, NUM_W'(acc));
					end
				end
				SCAN_LESS: begin
					if (c == kl_pkg::CH_GT) begin
						push(kl_pkg::TK_NE, 1'b0,
							TEXT_W'({kl_pkg::CH_GT, kl_pkg::CH_LT}), LEN_W'(2), '0);
						done = 1'b1;
					end else if (c == kl_pkg::CH_EQ) begin
						push(kl_pkg::TK_LE, 1'b0,
							TEXT_W'({kl_pkg::CH_EQ, kl_pkg::CH_LT}), LEN_W'(2), '0);
						done = 1'b1;
					end else begin
						push(kl_pkg::TK_LT, 1'b0, TEXT_W'(kl_pkg::CH_LT), LEN_W'(1), '0);
					end
				end
				SCAN_GREATER: begin
					if (c == kl_pkg::CH_EQ) begin
						push(kl_pkg::TK_GE, 1'b0,
							TEXT_W'({kl_pkg::CH_EQ, kl_pkg::CH_GT}), LEN_W'(2), '0);
						done = 1'b1;
					end else begin
						push(kl_pkg::TK_GT, 1'b0, TEXT_W'(kl_pkg::CH_GT), LEN_W'(1), '0);
					end
				end
				SCAN_COLON: begin
					if (c == kl_pkg::CH_EQ) begin
						push(kl_pkg::TK_ASSIGN, 1'b0,
							TEXT_W'({kl_pkg::CH_EQ, kl_pkg::CH_COLON}), LEN_W'(2), '0);
						done = 1'b1;
					end else begin
						push(kl_pkg::TK_COLON, 1'b0, TEXT_W'(kl_pkg::CH_COLON),
							LEN_W'(1), '0);
					end
				end
				default: ;
			endcase
			if (done) begin
				// a two-character operator or a word or number that goes on
				if (mode != SCAN_WORD && mode != SCAN_DIGITS)
					mode = SCAN_IDLE;
			end else begin
				mode = SCAN_IDLE;
				case (c)
					kl_pkg::CH_SP, kl_pkg::CH_CR: has_op = 1'b0;
					kl_pkg::CH_LF: begin
						has_op = 1'b0;
						if (row_cnt != '1)
							row_cnt++;
					end
					kl_pkg::CH_LT: begin
						has_op = 1'b0;
						mode   = SCAN_LESS;
					end
					kl_pkg::CH_GT: begin
						has_op = 1'b0;
						mode   = SCAN_GREATER;
					end
					kl_pkg::CH_COLON: begin
						has_op = 1'b0;
						mode   = SCAN_COLON;
					end
					kl_pkg::CH_STAR:  op = kl_pkg::TK_MUL;
					kl_pkg::CH_SLASH: op = kl_pkg::TK_DIV;
					kl_pkg::CH_PLUS:  op = kl_pkg::TK_ADD;
					kl_pkg::CH_MINUS: op = kl_pkg::TK_SUB;
					kl_pkg::CH_EQ:    op = kl_pkg::TK_EQ;
					kl_pkg::CH_SEMI:  op = kl_pkg::TK_SEMI;
					kl_pkg::CH_LPAR:  op = kl_pkg::TK_LPAREN;
					kl_pkg::CH_RPAR:  op = kl_pkg::TK_RPAREN;
					kl_pkg::CH_HASH:  op = kl_pkg::TK_END;
					default: begin
						has_op = 1'b0;
						if (is_alpha(c)) begin
							word    = TEXT_W'(c);
							n_chars = 1;
							mode    = SCAN_WORD;
						end else if (is_digit(c)) begin
							acc  = 32'(c - "0");
							mode = SCAN_DIGITS;
						end else begin
							// illegal character
							push(kl_pkg::TK_END, 1'b1, '0, '0, '0);
						end
					end
				endcase
				if (has_op) begin
					push(op, 1'b0, TEXT_W'(c), LEN_W'(1), '0);
					// end marker reports its row, then the count restarts
					if (c == kl_pkg::CH_HASH)
						row_cnt = ROW_W'(1);
				end
			end
			if (token_q.size() > size_at_entry)
				token_q[$].last = 1'b1;
		endfunction

		function string show(kl_pkg::token_t t);
			return $sformatf("kind %0d err %0d text %h len %0d num %0d row %0d last %0d",
				t.kind, t.is_error, t.text, t.len, t.num, t.row, t.last);
		endfunction

		function void flag(string what, kl_pkg::token_t want, kl_pkg::token_t got);
			errors++;
			if (errors <= 10)
				$display("%0t %s: expected %s, got %s", $time, what, show(want),
					show(got));
		endfunction

		function void check_token(logic [kl_pkg::OUT_DATA_W-1:0] d,
				logic [kl_pkg::OUT_USER_W-1:0] u, logic l);
			kl_pkg::token_t got;
			kl_pkg::token_t want;
			got.kind     = u[kl_pkg::KIND_W-1:0];
			got.is_error = u[kl_pkg::KIND_W];
			got.text     = d[TEXT_W-1:0];
			got.len      = d[TEXT_W +: LEN_W];
			got.num      = d[TEXT_W+LEN_W +: NUM_W];
			got.row      = d[TEXT_W+LEN_W+NUM_W +: ROW_W];
			got.last     = l;
			if (token_q.size() == 0) begin
				flag("unexpected item", '0, got);
				return;
			end
			want = token_q.pop_front();
			if (got.kind != want.kind || got.is_error != want.is_error ||
					got.text != want.text || got.len != want.len || got.num != want.num ||
					got.row != want.row || got.last != want.last)
				flag("mismatch", want, got);
		endfunction

		function void flush_missing();
			while (token_q.size() != 0)
				flag("missing item", token_q.pop_front(), '0);
		endfunction
	endclass

	logic                          clk           = 1'b0;
	logic                          arst_n        = 1'b1;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [7:0]                    s_axis_tdata  = '0;   // in_byte
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	// token_text, text_length, number_value, row_number, zero pad
	logic [kl_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	// token_kind, is_error
	logic [kl_pkg::OUT_USER_W-1:0] m_axis_tuser;
	logic                          m_axis_tlast;         // last_of_run

	token_scoreboard_t lexer_sb;

	// sender pacing
	bit          gaps_on    = 1'b0;
	int unsigned burst_left = 0;
	int unsigned bytes_sent = 0;

	// receiver pacing and the one long hold-off
	logic        hold_req = 1'b0;
	int unsigned hold_cnt = 0;
	logic [15:0] rx_cycle = '0;

	string op_text [0:14] = '{"*", "/", "+", "-", "=", ";", "(", ")", ":", ":=",
		"<", "<>", "<=", ">", ">="};

	keyword_lexer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// 12 ns clock
	always #6 clk = ~clk;

	// offer one byte, waiting out a random gap at the end of each burst
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(1, 7);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			// now and then a long burst with no idling at all
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		lexer_sb.note_byte(b);
		if (burst_left != 0)
			burst_left--;
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	function automatic logic [7:0] random_letter();
		int unsigned r;
		r = $urandom_range(0, 51);
		return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
	endfunction

	// receiver stall pattern, chosen by bits 8:6 of rx_cycle
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 16'd1;
		if (hold_req && hold_cnt < 90) begin
			// long hold-off so the token queue fills and the input stalls
			m_axis_tready <= 1'b0;
			hold_cnt      <= hold_cnt + 1;
		end else begin
			case (rx_cycle[8:6])
				3'd0, 3'd1: m_axis_tready <= 1'b1;
				3'd2:       m_axis_tready <= (rx_cycle[1:0] != 2'd3);
				3'd3:       m_axis_tready <= 1'($urandom_range(0, 1));
				3'd4:       m_axis_tready <= (rx_cycle[3:0] < 4'd3);
				default:    m_axis_tready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// every result the lexer hands out
	always @(posedge clk)
		if (m_axis_tvalid && m_axis_tready)
			lexer_sb.check_token(m_axis_tdata, m_axis_tuser, m_axis_tlast);

	initial begin
		int unsigned pick;
		int unsigned n;
		int unsigned v;
		int unsigned kw;
		int unsigned stop_at;
		int          k;
		logic [7:0]  ch;
		lexer_sb = new();
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		gaps_on = 1'b1;

		// directed: byte extremes, every lookahead operator, lookahead cut by
		// another operator, overlong identifier, number past the limit, end marker
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("<><=>=:=<:>Abcdefgh9 40000");
		send_byte(kl_pkg::CH_LF);
		send_byte(kl_pkg::CH_HASH);

		// random part, mostly well-formed tokens
		hold_req <= 1'b1;
		stop_at = bytes_sent + 620;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				// keyword, sometimes spoiled by case or an extra letter
				kw = $urandom_range(0, kl_pkg::KEYWORD_COUNT - 1);
				for (int j = 0; j < int'(kl_pkg::KW_LEN[kw]); j++) begin
					ch = kl_pkg::KW_TEXT[kw][8*j +: 8];
					if (j == 0 && $urandom_range(0, 5) == 0)
						ch = ch - 8'h20;
					send_byte(ch);
				end
				if ($urandom_range(0, 5) == 0)
					send_byte(random_letter());
			end else if (pick < 30) begin
				// identifier, short or past the kept length
				n = $urandom_range(1, 12);
				send_byte(random_letter());
				for (int j = 1; j < n; j++)
					send_byte(($urandom_range(0, 3) == 0) ? 8'("0" + $urandom_range(0, 9))
						: random_letter());
			end else if (pick < 45) begin
				// number, many of them around the limit
				case ($urandom_range(0, 3))
					0:       v = $urandom_range(0, 99);
					1:       v = $urandom_range(0, 32767);
					2:       v = $urandom_range(32760, 32775);
					default: v = $urandom_range(32768, 999999);
				endcase
				if ($urandom_range(0, 7) == 0)
					send_byte("0");
				send_text($sformatf("%0d", v));
			end else if (pick < 70) begin
				send_text(op_text[$urandom_range(0, 14)]);
			end else if (pick < 82) begin
				case ($urandom_range(0, 2))
					0:       send_byte(kl_pkg::CH_SP);
					1:       send_byte(kl_pkg::CH_CR);
					default: send_byte(kl_pkg::CH_LF);
				endcase
			end else if (pick < 86) begin
				send_byte(kl_pkg::CH_HASH);
			end else begin
				// noise
				send_byte(8'($urandom_range(0, 255)));
			end
		end

		// close whatever token is still pending
		send_byte(kl_pkg::CH_HASH);
		s_axis_tvalid <= 1'b0;

		// drain, then keep watching for anything extra
		for (k = 0; k < 5000 && lexer_sb.token_q.size() != 0; k++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		lexer_sb.flush_missing();
		if (lexer_sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
